### rtl/mdpr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and status decoders of the midi pad/encoder remapper
package mdpr_pkg;

   localparam int PAD_COUNT_DEF     = 64;
   localparam int ENCODER_COUNT_DEF = 8;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);

   localparam logic [8:0] PAD_BASE    = 9'd36;
   localparam logic [8:0] ENC_BASE    = 9'd71;
   localparam logic [6:0] CC_SUSTAIN  = 7'd64;
   localparam logic [6:0] CC_MODWHEEL = 7'd1;

   localparam logic [1:0] KIND_KEYS  = 2'd0;
   localparam logic [1:0] KIND_PADS  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [7:0] NO_ENTRY = 8'hFF;

   typedef enum logic [2:0] {
      ACT_DROP,
      ACT_PASS,
      ACT_KEYB,
      ACT_PAD,
      ACT_ENC
   } act_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        status_byte;
      logic [6:0]        first_data;
      logic [6:0]        second_data;
      logic [6:0]        map_index;
      logic signed [7:0] map_entry;
   } req_type;

   typedef struct packed {
      logic [7:0] out_status;
      logic [6:0] out_first;
      logic [6:0] out_second;
   } rsp_type;

   // classified message with its table entry, handed from front to back
   typedef struct packed {
      act_type    act;
      logic [7:0] status;
      logic [6:0] d1;
      logic [6:0] d2;
      logic [7:0] entry;
   } work_type;

   function automatic logic is_note(input logic [7:0] st);
      return st[7:5] == 3'b100;
   endfunction

   function automatic logic is_touch(input logic [7:0] st);
      return st[7:4] == 4'hA;
   endfunction

   function automatic logic is_ctrl(input logic [7:0] st);
      return st[7:4] == 4'hB;
   endfunction

   function automatic logic is_press(input logic [7:0] st);
      return st[7:4] == 4'hD;
   endfunction

   function automatic logic is_bend(input logic [7:0] st);
      return st[7:4] == 4'hE;
   endfunction

endpackage

### rtl/mdpr_front.sv
`timescale 1ns / 1ps
// front end: accepts items, classifies them, owns the map tables and looks up entries
module mdpr_front #(
   parameter int PAD_COUNT     = mdpr_pkg::PAD_COUNT_DEF,
   parameter int ENCODER_COUNT = mdpr_pkg::ENCODER_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mdpr_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output mdpr_pkg::work_type push_data
);

   localparam int SLOT_COUNT = PAD_COUNT + ENCODER_COUNT;
   localparam int AW         = $clog2(SLOT_COUNT);
   localparam logic [8:0] PAD_N  = 9'(PAD_COUNT);
   localparam logic [8:0] ENC_N  = 9'(ENCODER_COUNT);
   localparam logic [8:0] SLOT_N = 9'(SLOT_COUNT);

   // pad slots first, encoder slots right after them
   logic [7:0]            map_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] vld_ff;
   logic [SLOT_COUNT-1:0] vld_in;

   logic                  s1_valid_ff, s1_valid_in;
   mdpr_pkg::act_type     s1_act_ff;
   logic [7:0]            s1_status_ff;
   logic [6:0]            s1_d1_ff;
   logic [6:0]            s1_d2_ff;
   logic [7:0]            rd_data_ff;
   logic                  rd_vld_ff;

   logic                  accept;
   logic                  load;
   logic                  push_fire;
   mdpr_pkg::act_type     act;
   logic [8:0]            d1_w;
   logic [8:0]            idx_w;
   logic [8:0]            pad_off;
   logic [8:0]            enc_slot;
   logic                  pad_hit;
   logic                  enc_hit;
   logic                  wr_hit;
   logic [AW-1:0]         rd_slot;
   logic [AW-1:0]         wr_slot;
   logic [7:0]            st;

   assign st       = req_data.status_byte;
   assign d1_w     = {2'b00, req_data.first_data};
   assign idx_w    = {2'b00, req_data.map_index};
   assign pad_off  = d1_w - mdpr_pkg::PAD_BASE;
   assign enc_slot = PAD_N + d1_w - mdpr_pkg::ENC_BASE;
   assign pad_hit  = (d1_w >= mdpr_pkg::PAD_BASE) && (pad_off < PAD_N);
   assign enc_hit  = (d1_w >= mdpr_pkg::ENC_BASE) && ((d1_w - mdpr_pkg::ENC_BASE) < ENC_N);
   assign wr_hit   = (req_data.kind == mdpr_pkg::KIND_WRITE) && (idx_w < SLOT_N);
   assign wr_slot  = idx_w[AW-1:0];

   always_comb begin
      act = mdpr_pkg::ACT_DROP;
      if (req_data.kind == mdpr_pkg::KIND_KEYS) begin
         act = mdpr_pkg::ACT_KEYB;
      end else if (req_data.kind == mdpr_pkg::KIND_PADS) begin
         if ((mdpr_pkg::is_ctrl(st) && (req_data.first_data == mdpr_pkg::CC_SUSTAIN ||
              req_data.first_data == mdpr_pkg::CC_MODWHEEL)) || mdpr_pkg::is_bend(st)) begin
            act = mdpr_pkg::ACT_PASS;
         end else if (mdpr_pkg::is_note(st) || mdpr_pkg::is_touch(st) ||
                      mdpr_pkg::is_press(st)) begin
            act = pad_hit ? mdpr_pkg::ACT_PAD : mdpr_pkg::ACT_DROP;
         end else if (mdpr_pkg::is_ctrl(st)) begin
            act = enc_hit ? mdpr_pkg::ACT_ENC : mdpr_pkg::ACT_DROP;
         end
      end
   end

   always_comb begin
      rd_slot = '0;
      if (act == mdpr_pkg::ACT_PAD) begin
         rd_slot = pad_off[AW-1:0];
      end else if (act == mdpr_pkg::ACT_ENC) begin
         rd_slot = enc_slot[AW-1:0];
      end
   end

   assign push_fire   = s1_valid_ff && push_ready;
   assign req_stall   = s1_valid_ff && !push_ready;
   assign accept      = req_valid && !req_stall;
   assign load        = accept && (act != mdpr_pkg::ACT_DROP);
   assign s1_valid_in = load ? 1'b1 : (push_fire ? 1'b0 : s1_valid_ff);

   always_comb begin
      vld_in = vld_ff;
      if (accept && wr_hit) begin
         vld_in[wr_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         vld_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         vld_ff      <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_hit) begin
         map_mem[wr_slot] <= req_data.map_entry;
      end
      if (accept) begin
         rd_data_ff <= map_mem[rd_slot];
         rd_vld_ff  <= vld_ff[rd_slot];
      end
      if (load) begin
         s1_act_ff    <= act;
         s1_status_ff <= st;
         s1_d1_ff     <= req_data.first_data;
         s1_d2_ff     <= req_data.second_data;
      end
   end

   assign push_valid       = s1_valid_ff;
   assign push_data.act    = s1_act_ff;
   assign push_data.status = s1_status_ff;
   assign push_data.d1     = s1_d1_ff;
   assign push_data.d2     = s1_d2_ff;
   // a slot never written reads as discard
   assign push_data.entry  = rd_vld_ff ? rd_data_ff : mdpr_pkg::NO_ENTRY;

endmodule

### rtl/mdpr_queue.sv
`timescale 1ns / 1ps
// short fifo of classified items between front and back
module mdpr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mdpr_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_en,
   output mdpr_pkg::work_type pop_data
);

   localparam logic [mdpr_pkg::QUEUE_AW:0] FULL = (mdpr_pkg::QUEUE_AW + 1)'(mdpr_pkg::QUEUE_DEPTH);

   mdpr_pkg::work_type            slot_ff [mdpr_pkg::QUEUE_DEPTH];
   logic [mdpr_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mdpr_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mdpr_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign push_ready = count_ff != FULL;
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_en && pop_valid;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/mdpr_back.sv
`timescale 1ns / 1ps
// back end: applies remap, drop and fixed velocity, holds the result register
module mdpr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic signed [7:0]  csr_wr_data,
   input  logic               pop_valid,
   output logic               pop_en,
   input  mdpr_pkg::work_type pop_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mdpr_pkg::rsp_type  rsp_data
);

   logic [7:0]        fv_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   mdpr_pkg::rsp_type rsp_data_ff;
   logic              keep;
   logic              fv_on;
   logic              note;
   logic [6:0]        d1;
   logic [6:0]        d2;

   assign fv_on  = !fv_ff[7];
   assign note   = mdpr_pkg::is_note(pop_data.status);
   assign pop_en = pop_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      keep = 1'b1;
      d1   = pop_data.d1;
      d2   = pop_data.d2;
      unique case (pop_data.act)
         mdpr_pkg::ACT_KEYB: begin
            if (note && fv_on) d2 = fv_ff[6:0];
         end
         mdpr_pkg::ACT_PASS: begin
         end
         mdpr_pkg::ACT_PAD: begin
            if (pop_data.entry[7]) begin
               keep = 1'b0;
            end else begin
               // channel pressure only passes or drops
               if (note || mdpr_pkg::is_touch(pop_data.status)) d1 = pop_data.entry[6:0];
               if (note && fv_on) d2 = fv_ff[6:0];
            end
         end
         mdpr_pkg::ACT_ENC: begin
            if (pop_data.entry[7]) begin
               keep = 1'b0;
            end else begin
               d1 = pop_data.entry[6:0];
            end
         end
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_en) begin
         rsp_valid_in = keep;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff        <= mdpr_pkg::NO_ENTRY;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fv_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_en && keep) begin
         rsp_data_ff.out_status <= pop_data.status;
         rsp_data_ff.out_first  <= d1;
         rsp_data_ff.out_second <= d2;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/midi_pad_encoder_remapper_top.sv
`timescale 1ns / 1ps
// top level of the midi pad/encoder remapper
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  mdpr_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  mdpr_pkg::rsp_type
//   csr      in         csr_wr_en            csr_wr_data (fixed velocity)
//
// one item per cycle sustained while rsp does not stall; a message item passes through the
// front stage, a queue slot and the result register on its way to rsp
// synchronous reset marks every table slot as discard and sets fixed velocity off
// a stall on rsp holds up to six message items (result register, four-entry queue,
// front stage) before req stalls; map writes and items the front drops take no queue space
module midi_pad_encoder_remapper_top #(
   parameter int PAD_COUNT     = mdpr_pkg::PAD_COUNT_DEF,
   parameter int ENCODER_COUNT = mdpr_pkg::ENCODER_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mdpr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mdpr_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic signed [7:0] csr_wr_data
);

   logic               push_valid;
   logic               push_ready;
   mdpr_pkg::work_type push_data;
   logic               pop_valid;
   logic               pop_en;
   mdpr_pkg::work_type pop_data;

   mdpr_front #(
      .PAD_COUNT     (PAD_COUNT),
      .ENCODER_COUNT (ENCODER_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mdpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_en     (pop_en),
      .pop_data   (pop_data)
   );

   mdpr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_en      (pop_en),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
